// ===== design/mtnc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the markup tag nesting checker: token and event codes,
// transaction payload structs, the relevant tag name table. No dependencies.
package mtnc_pkg;

    // Parameter defaults
    localparam int STACK_DEPTH_DEF = 64;
    localparam int NAME_CHARS_DEF  = 8;

    // Token kinds on the input channel
    typedef enum logic [3:0] {
        REQ_LT     = 4'd0,
        REQ_GT     = 4'd1,
        REQ_OPEN   = 4'd2,
        REQ_CLOSE  = 4'd3,
        REQ_WORD   = 4'd4,
        REQ_HYPHEN = 4'd5,
        REQ_NUMBER = 4'd6,
        REQ_APOS   = 4'd7,
        REQ_PUNCT  = 4'd8,
        REQ_OTHER  = 4'd9,
        REQ_END    = 4'd10
    } req_type_t;

    // Event codes on the result channel
    typedef enum logic [3:0] {
        EV_OPEN           = 4'd0,
        EV_CLOSE          = 4'd1,
        EV_WORD           = 4'd2,
        EV_HYPHEN         = 4'd3,
        EV_NUMBER         = 4'd4,
        EV_APOS           = 4'd5,
        EV_PUNCT          = 4'd6,
        EV_CLOSE_MISMATCH = 4'd7,
        EV_SKIP_MISMATCH  = 4'd8,
        EV_END            = 4'd9
    } event_t;

    // Input transaction
    typedef struct packed {
        logic [3:0]  req_type;
        logic [63:0] tag_name;
        logic [31:0] token_ref;
    } token_t;

    // Result transaction
    typedef struct packed {
        logic [3:0]  event_res;
        logic [63:0] name_out;
        logic [63:0] expected_name;
        logic [31:0] text_ref;
        logic [6:0]  main_depth;
        logic [6:0]  skip_depth;
        logic        overflowed;
    } result_t;

    // Relevant tag names, first character in the low byte
    localparam int NUM_RELEVANT = 7;
    localparam logic [63:0] RELEVANT_NAMES [NUM_RELEVANT] = '{
        64'h0000_0000_5458_4554,    // TEXT
        64'h0000_0000_4554_4144,    // DATE
        64'h0000_0000_0043_4F44,    // DOC
        64'h0000_004F_4E43_4F44,    // DOCNO
        64'h454E_494C_4441_4548,    // HEADLINE
        64'h0000_4854_474E_454C,    // LENGTH
        64'h0000_0000_0000_0050     // P
    };

    // Name match against the table, table entries cut to the name mask
    function automatic logic is_relevant(input logic [63:0] name,
                                         input logic [63:0] mask);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_RELEVANT; i++) begin
            if (name == (RELEVANT_NAMES[i] & mask)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// ===== design/mtnc_stack_mem.sv =====
`timescale 1ns / 1ps
// Stack storage: one write port, one registered read port, with
// write-to-read bypass on a same-address access. Uses no package.
module mtnc_stack_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, newest data wins on a same-address write
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mtnc_ctrl.sv =====
`timescale 1ns / 1ps
// Token decoder and stack control: flags, stack counts, push/pop and
// result building. Depends on mtnc_pkg; stack tops come from mtnc_stack_mem.
module mtnc_ctrl #(
    parameter int STACK_DEPTH = mtnc_pkg::STACK_DEPTH_DEF,
    parameter int NAME_CHARS  = mtnc_pkg::NAME_CHARS_DEF,
    parameter int NAME_W      = 8 * NAME_CHARS,
    parameter int AW          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    parameter int CW          = $clog2(STACK_DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  mtnc_pkg::token_t    token,
    // relevant stack
    input  logic [NAME_W-1:0]   rel_top,
    output logic                rel_wr_en,
    output logic [AW-1:0]       rel_wr_addr,
    output logic [AW-1:0]       rel_rd_addr,
    // skipped stack
    input  logic [NAME_W-1:0]   skp_top,
    output logic                skp_wr_en,
    output logic [AW-1:0]       skp_wr_addr,
    output logic [AW-1:0]       skp_rd_addr,
    output logic [NAME_W-1:0]   push_name,
    // result
    output logic                res_valid,
    output mtnc_pkg::result_t   res
);

    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [63:0] NAME_MASK = 64'({NAME_W{1'b1}});

    logic          rel_reg, rel_next;
    logic          cap_reg, cap_next;
    logic          tag_reg, tag_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] rcnt_reg, rcnt_next;
    logic [CW-1:0] scnt_reg, scnt_next;
    logic [CW-1:0] rcnt_dec, scnt_dec, scnt_less;

    logic [NAME_W-1:0] n;
    logic [63:0]       n64;
    logic [3:0]        t;
    logic              rel_hit, rel_match, skp_match;
    logic              open_req, rpush, spush;

    assign n         = token.tag_name[NAME_W-1:0];
    assign n64       = 64'(n);
    assign t         = token.req_type;
    assign rel_hit   = mtnc_pkg::is_relevant(n64, NAME_MASK);
    assign rel_match = (rcnt_reg != '0) && (rel_top == n);
    assign skp_match = (scnt_reg != '0) && (skp_top == n);
    assign scnt_less = scnt_reg - CW'(1);
    assign push_name = n;

    // Token decode and next state
    always_comb begin
        rel_next  = rel_reg;
        cap_next  = cap_reg;
        tag_next  = tag_reg;
        ovf_next  = ovf_reg;
        rcnt_next = rcnt_reg;
        scnt_next = scnt_reg;
        open_req  = 1'b0;
        rpush     = 1'b0;
        spush     = 1'b0;
        res_valid = 1'b0;
        res       = '0;

        if (accept) begin
            if (t == mtnc_pkg::REQ_END) begin
                res_valid      = 1'b1;
                res.event_res  = mtnc_pkg::EV_END;
                res.main_depth = 7'(rcnt_reg);
                res.skip_depth = 7'(scnt_reg);
            end else if (rel_reg) begin
                // relevant region
                if (t == mtnc_pkg::REQ_LT && !cap_reg && !tag_reg) begin
                    cap_next = 1'b1;
                    tag_next = 1'b1;
                end else if (t == mtnc_pkg::REQ_OPEN) begin
                    open_req = 1'b1;
                end else if (t == mtnc_pkg::REQ_GT && tag_reg) begin
                    tag_next = 1'b0;
                end else if (t != mtnc_pkg::REQ_CLOSE && !cap_reg && !tag_reg) begin
                    res.text_ref = token.token_ref;
                    unique case (t)
                        mtnc_pkg::REQ_WORD: begin
                            res_valid     = 1'b1;
                            res.event_res = mtnc_pkg::EV_WORD;
                        end
                        mtnc_pkg::REQ_HYPHEN: begin
                            res_valid     = 1'b1;
                            res.event_res = mtnc_pkg::EV_HYPHEN;
                        end
                        mtnc_pkg::REQ_NUMBER: begin
                            res_valid     = 1'b1;
                            res.event_res = mtnc_pkg::EV_NUMBER;
                        end
                        mtnc_pkg::REQ_APOS: begin
                            res_valid     = 1'b1;
                            res.event_res = mtnc_pkg::EV_APOS;
                        end
                        mtnc_pkg::REQ_PUNCT: begin
                            res_valid     = 1'b1;
                            res.event_res = mtnc_pkg::EV_PUNCT;
                        end
                        default: begin
                            res.text_ref = '0;
                        end
                    endcase
                end else if (t == mtnc_pkg::REQ_WORD && cap_reg && tag_reg) begin
                    // captured word after '<' names the tag
                    open_req = 1'b1;
                end else if (t == mtnc_pkg::REQ_WORD && !cap_reg && tag_reg) begin
                    // attribute word, ignored
                end else if (t == mtnc_pkg::REQ_CLOSE && rel_hit) begin
                    res_valid    = 1'b1;
                    res.name_out = n64;
                    if (rel_match) begin
                        rcnt_next     = rcnt_reg - CW'(1);
                        res.event_res = mtnc_pkg::EV_CLOSE;
                    end else begin
                        res.event_res = mtnc_pkg::EV_CLOSE_MISMATCH;
                    end
                end
            end else begin
                // skipped region
                if (t == mtnc_pkg::REQ_OPEN) begin
                    spush = 1'b1;
                end else if (t == mtnc_pkg::REQ_CLOSE) begin
                    if (skp_match) begin
                        scnt_next = scnt_less;
                        if (scnt_less == '0) begin
                            rel_next = 1'b1;
                        end
                    end else begin
                        res_valid     = 1'b1;
                        res.event_res = mtnc_pkg::EV_SKIP_MISMATCH;
                        res.name_out  = n64;
                        if (scnt_reg != '0) begin
                            res.expected_name = 64'(skp_top);
                        end
                    end
                end else if (t == mtnc_pkg::REQ_LT && !cap_reg) begin
                    tag_next = 1'b1;
                    cap_next = 1'b1;
                end else if (t == mtnc_pkg::REQ_WORD && cap_reg) begin
                    cap_next = 1'b0;
                    spush    = 1'b1;
                end else if (t == mtnc_pkg::REQ_GT && tag_reg) begin
                    tag_next = 1'b0;
                end
            end
        end

        // Tag opening in a relevant region
        if (open_req) begin
            cap_next = 1'b0;
            if (rel_hit) begin
                rpush         = 1'b1;
                res_valid     = 1'b1;
                res.event_res = mtnc_pkg::EV_OPEN;
                res.name_out  = n64;
            end else begin
                rel_next = 1'b0;
                spush    = 1'b1;
            end
        end

        // Pushes, dropped on a full stack
        rel_wr_en = 1'b0;
        skp_wr_en = 1'b0;
        if (rpush) begin
            if (rcnt_reg >= FULL) begin
                ovf_next = 1'b1;
            end else begin
                rel_wr_en = 1'b1;
                rcnt_next = rcnt_reg + CW'(1);
            end
        end
        if (spush) begin
            if (scnt_reg >= FULL) begin
                ovf_next = 1'b1;
            end else begin
                skp_wr_en = 1'b1;
                scnt_next = scnt_reg + CW'(1);
            end
        end

        res.overflowed = ovf_next;
    end

    // Memory addressing: read the top that the next token will see
    assign rcnt_dec    = rcnt_next - CW'(1);
    assign scnt_dec    = scnt_next - CW'(1);
    assign rel_rd_addr = rcnt_dec[AW-1:0];
    assign skp_rd_addr = scnt_dec[AW-1:0];
    assign rel_wr_addr = rcnt_reg[AW-1:0];
    assign skp_wr_addr = scnt_reg[AW-1:0];

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rel_reg  <= 1'b1;
            cap_reg  <= 1'b0;
            tag_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            rcnt_reg <= '0;
            scnt_reg <= '0;
        end else begin
            rel_reg  <= rel_next;
            cap_reg  <= cap_next;
            tag_reg  <= tag_next;
            ovf_reg  <= ovf_next;
            rcnt_reg <= rcnt_next;
            scnt_reg <= scnt_next;
        end
    end

endmodule

// ===== design/mtnc_out_buf.sv =====
`timescale 1ns / 1ps
// Two-entry result buffer: output register plus skid register, so a new
// token is taken while one result waits. Depends on mtnc_pkg.
module mtnc_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mtnc_pkg::result_t  push_data,
    output logic               space,
    output logic               m_valid,
    input  logic               m_ready,
    output mtnc_pkg::result_t  m_data
);

    logic              out_valid_reg, skid_valid_reg;
    mtnc_pkg::result_t out_data_reg, skid_data_reg;
    logic              pop;

    assign pop     = out_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push && out_valid_reg && !pop) begin
            skid_valid_reg <= 1'b1;
        end else if (push) begin
            out_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push && out_valid_reg && !pop) begin
            skid_data_reg <= push_data;
        end else if (push) begin
            out_data_reg <= push_data;
        end
    end

endmodule

// ===== design/markup_tag_nesting_checker.sv =====
`timescale 1ns / 1ps
// Markup tag nesting checker, top level. Depends on mtnc_pkg, mtnc_stack_mem,
// mtnc_ctrl and mtnc_out_buf.
//
// Takes one scanned markup token per cycle and checks tag nesting on two
// stacks, each held in a STACK_DEPTH-entry memory: one for the relevant tags
// (TEXT, DATE, DOC, DOCNO, HEADLINE, LENGTH, P) and one for skipped regions.
// A token is taken every cycle as long as fewer than two results wait at the
// output. A token's result, if any, appears on the m_ channel the cycle after
// the token is accepted when no earlier result is waiting there; otherwise it
// follows as soon as the results ahead of it have been taken. The stack tops
// come from the memory read ports, addressed each cycle from the updated stack
// counts, with write bypass, so pushes and pops follow back to back. Memories
// need no clearing pass after reset: an entry is only read below the current
// count. Only the low NAME_CHARS bytes of a name count; a push to a full stack
// is dropped and sets the sticky overflowed flag, and depths report modulo 128.
module markup_tag_nesting_checker #(
    parameter int STACK_DEPTH = mtnc_pkg::STACK_DEPTH_DEF,
    parameter int NAME_CHARS  = mtnc_pkg::NAME_CHARS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  mtnc_pkg::token_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output mtnc_pkg::result_t  m_data
);

    localparam int NAME_W = 8 * NAME_CHARS;
    localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW     = $clog2(STACK_DEPTH + 1);

    logic              accept;
    logic [NAME_W-1:0] rel_top, skp_top, push_name;
    logic              rel_wr_en, skp_wr_en;
    logic [AW-1:0]     rel_wr_addr, rel_rd_addr, skp_wr_addr, skp_rd_addr;
    logic              res_valid;
    mtnc_pkg::result_t res;

    assign accept = s_valid && s_ready;

    // Relevant tag stack
    mtnc_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (NAME_W),
        .AW    (AW)
    ) u_rel_mem (
        .aclk    (aclk),
        .wr_en   (rel_wr_en),
        .wr_addr (rel_wr_addr),
        .wr_data (push_name),
        .rd_addr (rel_rd_addr),
        .rd_data (rel_top)
    );

    // Skipped tag stack
    mtnc_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (NAME_W),
        .AW    (AW)
    ) u_skp_mem (
        .aclk    (aclk),
        .wr_en   (skp_wr_en),
        .wr_addr (skp_wr_addr),
        .wr_data (push_name),
        .rd_addr (skp_rd_addr),
        .rd_data (skp_top)
    );

    // Token decode and stack control
    mtnc_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .NAME_CHARS  (NAME_CHARS),
        .NAME_W      (NAME_W),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .token       (s_data),
        .rel_top     (rel_top),
        .rel_wr_en   (rel_wr_en),
        .rel_wr_addr (rel_wr_addr),
        .rel_rd_addr (rel_rd_addr),
        .skp_top     (skp_top),
        .skp_wr_en   (skp_wr_en),
        .skp_wr_addr (skp_wr_addr),
        .skp_rd_addr (skp_rd_addr),
        .push_name   (push_name),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result buffer
    mtnc_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
